FILE: rtl/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int LIMIT_BITS         = 35;
  localparam int QUEUE_DEPTH        = 4;
  localparam int VERDICT_BITS       = 2;
  localparam int OUT_TDATA_BITS     = 8;

  typedef enum logic [VERDICT_BITS-1:0] {
    VERDICT_CONVEX    = 2'd0,
    VERDICT_OPPOSITE  = 2'd1,
    VERDICT_COLLINEAR = 2'd2,
    VERDICT_SHORT     = 2'd3
  } verdict_t;

  // flags carried with each queued job
  typedef struct packed {
    logic last;        // closing vertex: wrap-around turns follow
    logic short_poly;  // fewer than three vertices, nothing to judge
  } job_flags_t;

  localparam int FLAG_BITS = $bits(job_flags_t);

  // points held in one job: older, newer, current, first, second
  localparam int JOB_POINTS = 5;

endpackage

`default_nettype wire

FILE: rtl/pcc_front.sv
`default_nettype none

module pcc_front #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEFAULT,
  localparam int PW = 2 * COORD_BITS,
  localparam int JW = pcc_pkg::JOB_POINTS * PW + pcc_pkg::FLAG_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [COORD_BITS-1:0] x_coord,
  input  wire logic [COORD_BITS-1:0] y_coord,
  input  wire logic                  last_vertex,
  output logic                       push,
  output logic [JW-1:0]              job
);

  logic [1:0]    tally;
  logic [PW-1:0] first_pt;
  logic [PW-1:0] second_pt;
  logic [PW-1:0] older_pt;
  logic [PW-1:0] newer_pt;
  logic [PW-1:0] cur_pt;
  pcc_pkg::job_flags_t flags;

  assign cur_pt = {y_coord, x_coord};

  always_comb begin
    flags.last       = last_vertex;
    flags.short_poly = last_vertex && (tally < 2'd2);
  end

  // a vertex makes work for the back end once a turn can be formed, or when it closes
  assign push = accept && (last_vertex || tally >= 2'd2);
  assign job  = {flags, second_pt, first_pt, cur_pt, newer_pt, older_pt};

  always_ff @(posedge clk) begin
    if (rst) begin
      tally     <= '0;
      first_pt  <= '0;
      second_pt <= '0;
      older_pt  <= '0;
      newer_pt  <= '0;
    end else if (accept) begin
      if (last_vertex) begin
        tally     <= '0;
        first_pt  <= '0;
        second_pt <= '0;
        older_pt  <= '0;
        newer_pt  <= '0;
      end else begin
        if (tally == 2'd0) first_pt <= cur_pt;
        if (tally == 2'd1) second_pt <= cur_pt;
        older_pt <= newer_pt;
        newer_pt <= cur_pt;
        if (tally != 2'd3) tally <= tally + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pcc_queue.sv
`default_nettype none

module pcc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcc_pkg::QUEUE_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = store[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pcc_back.sv
`default_nettype none

module pcc_back #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEFAULT,
  localparam int PW  = 2 * COORD_BITS,
  localparam int JW  = pcc_pkg::JOB_POINTS * PW + pcc_pkg::FLAG_BITS,
  localparam int LW  = pcc_pkg::LIMIT_BITS,
  localparam int DW  = COORD_BITS + 1,
  localparam int MW  = 2 * DW,
  localparam int XW  = MW + 1,
  localparam int CMW = (XW > LW) ? XW : LW
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [LW-1:0]                      cfg_wdata,
  input  wire logic                               job_valid,
  input  wire logic [JW-1:0]                      job,
  output logic                                    job_pop,
  output logic                                    out_valid,
  output logic [pcc_pkg::VERDICT_BITS-1:0]        out_verdict,
  input  wire logic                               out_ready
);

  localparam logic [1:0] LAST_TRIPLE = 2'd2;

  logic [LW-1:0] limit;

  // sequencer over the turns of the job at the queue head
  logic [1:0]          triple;
  pcc_pkg::job_flags_t jflags;
  logic [PW-1:0]       pa, pb, pc;
  logic                issue;
  logic                job_done;
  logic                stall;

  // pipeline: differences, products, turn, then judge
  logic                 s1_valid, s1_final, s1_short;
  logic                 s2_valid, s2_final, s2_short;
  logic                 s3_valid, s3_final, s3_short;
  logic signed [DW-1:0] d1, d2, d3, d4;
  logic signed [DW-1:0] d1_next, d2_next, d3_next, d4_next;
  logic signed [MW-1:0] prod_p, prod_q;
  logic signed [XW-1:0] turn;

  logic          neg;
  logic [XW-1:0] mag;
  logic          significant;
  logic          retire;

  logic ref_seen, ref_neg, conflict;
  logic ref_seen_next, ref_neg_next, conflict_next;
  pcc_pkg::verdict_t verdict_next;

  assign jflags = pcc_pkg::job_flags_t'(job[pcc_pkg::JOB_POINTS*PW +: pcc_pkg::FLAG_BITS]);

  always_comb begin
    case (triple)
      2'd0: begin
        pa = job[0*PW +: PW];
        pb = job[1*PW +: PW];
        pc = job[2*PW +: PW];
      end
      2'd1: begin
        pa = job[1*PW +: PW];
        pb = job[2*PW +: PW];
        pc = job[3*PW +: PW];
      end
      default: begin
        pa = job[2*PW +: PW];
        pb = job[3*PW +: PW];
        pc = job[4*PW +: PW];
      end
    endcase
  end

  // only a closing job ahead of a busy output register holds the pipe
  assign stall    = s3_valid && s3_final && out_valid && !out_ready;
  assign issue    = job_valid && !stall;
  assign job_done = jflags.short_poly || !jflags.last || (triple == LAST_TRIPLE);
  assign job_pop  = issue && job_done;
  assign retire   = s3_valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      triple <= '0;
    end else if (issue) begin
      triple <= job_done ? 2'd0 : triple + 2'd1;
    end
  end

  // point layout: x in the low half, y in the high half
  assign d1_next = {pb[COORD_BITS-1], pb[COORD_BITS-1:0]}
                 - {pa[COORD_BITS-1], pa[COORD_BITS-1:0]};
  assign d2_next = {pc[PW-1], pc[PW-1:COORD_BITS]}
                 - {pb[PW-1], pb[PW-1:COORD_BITS]};
  assign d3_next = {pb[PW-1], pb[PW-1:COORD_BITS]}
                 - {pa[PW-1], pa[PW-1:COORD_BITS]};
  assign d4_next = {pc[COORD_BITS-1], pc[COORD_BITS-1:0]}
                 - {pb[COORD_BITS-1], pb[COORD_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_final <= job_done && jflags.last;
      s1_short <= jflags.short_poly;
      d1       <= d1_next;
      d2       <= d2_next;
      d3       <= d3_next;
      d4       <= d4_next;
      s2_final <= s1_final;
      s2_short <= s1_short;
      prod_p   <= d1 * d2;
      prod_q   <= d3 * d4;
      s3_final <= s2_final;
      s3_short <= s2_short;
      turn     <= {prod_p[MW-1], prod_p} - {prod_q[MW-1], prod_q};
    end
  end

  assign neg         = turn[XW-1];
  assign mag         = neg ? (~turn + 1'b1) : turn;
  assign significant = (CMW'(mag) > CMW'(limit)) && !s3_short;

  always_comb begin
    ref_seen_next = ref_seen;
    ref_neg_next  = ref_neg;
    conflict_next = conflict;
    if (significant) begin
      if (!ref_seen) begin
        ref_seen_next = 1'b1;
        ref_neg_next  = neg;
      end else if (ref_neg != neg) begin
        conflict_next = 1'b1;
      end
    end
  end

  always_comb begin
    if (s3_short)           verdict_next = pcc_pkg::VERDICT_SHORT;
    else if (conflict_next) verdict_next = pcc_pkg::VERDICT_OPPOSITE;
    else if (!ref_seen_next) verdict_next = pcc_pkg::VERDICT_COLLINEAR;
    else                    verdict_next = pcc_pkg::VERDICT_CONVEX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_seen  <= 1'b0;
      ref_neg   <= 1'b0;
      conflict  <= 1'b0;
      out_valid <= 1'b0;
      limit     <= '0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      if (retire) begin
        if (s3_final) begin
          ref_seen <= 1'b0;
          ref_neg  <= 1'b0;
          conflict <= 1'b0;
        end else begin
          ref_seen <= ref_seen_next;
          ref_neg  <= ref_neg_next;
          conflict <= conflict_next;
        end
      end
      if (retire && s3_final) out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && s3_final) out_verdict <= verdict_next;
  end

endmodule

`default_nettype wire

FILE: rtl/polygon_convexity_check.sv
`default_nettype none

// Polygon convexity check. Vertices stream in one per transaction (x in the low
// half of s_tdata, y above, s_tlast on the closing vertex); each closing vertex
// yields one verdict transaction: 0 convex, 1 turns of opposite sign, 2 all
// collinear, 3 fewer than three vertices. Turns whose magnitude (Q.8) is at or
// below the limit written through cfg_we/cfg_wdata count as straight. A vertex
// is taken every cycle while the job queue is not full; the closing vertex of a
// polygon with three or more vertices costs the turn unit its own turn plus the
// two wrap-around turns, absorbed by a four-entry job queue in front of it. With
// the queue empty and the output free, the two wrap-around turns issue behind
// the closing vertex (none for a polygon of fewer than three vertices), then
// the difference, multiply, subtract and judge stages of the turn pipeline
// register the verdict and raise m_tvalid.

module polygon_convexity_check #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEFAULT,
  localparam int IN_TW = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int JW    = pcc_pkg::JOB_POINTS * 2 * COORD_BITS + pcc_pkg::FLAG_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [pcc_pkg::LIMIT_BITS-1:0]      cfg_wdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [IN_TW-1:0]                    s_tdata,   // x_coord, y_coord
  input  wire logic                                s_tlast,   // last_vertex
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [pcc_pkg::OUT_TDATA_BITS-1:0]       m_tdata    // verdict
);

  logic          accept;
  logic          push;
  logic [JW-1:0] push_job;
  logic          q_full;
  logic          pop;
  logic          head_valid;
  logic [JW-1:0] head_job;
  logic [pcc_pkg::VERDICT_BITS-1:0] verdict;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {{(pcc_pkg::OUT_TDATA_BITS - pcc_pkg::VERDICT_BITS){1'b0}}, verdict};

  pcc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .x_coord     (s_tdata[COORD_BITS-1:0]),
    .y_coord     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .last_vertex (s_tlast),
    .push        (push),
    .job         (push_job)
  );

  pcc_queue #(.WIDTH(JW), .DEPTH(pcc_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_job)
  );

  pcc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .job_valid   (head_valid),
    .job         (head_job),
    .job_pop     (pop),
    .out_valid   (m_tvalid),
    .out_verdict (verdict),
    .out_ready   (m_tready)
  );

endmodule

`default_nettype wire
